### src/bmp_pkg.sv
// Shared types and constants of the BMP pixel row decoder.
// Used by bmp_unpack and bmp_pixel_row_decoder; no dependencies.
`default_nettype none

package bmp_pkg;

  localparam int unsigned IdxW = 24;

  typedef enum logic [2:0] {
    CfgMode32   = 3'd0,
    CfgWidth    = 3'd1,
    CfgHeight   = 3'd2,
    CfgBottomUp = 3'd3,
    CfgMaskRed  = 3'd4,
    CfgMaskGrn  = 3'd5,
    CfgMaskBlu  = 3'd6,
    CfgMaskAlp  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] mask;
    logic [4:0]  shift;
  } chan_cfg_t;

  typedef struct packed {
    chan_cfg_t alpha;
    chan_cfg_t red;
    chan_cfg_t green;
    chan_cfg_t blue;
  } chan_set_t;

  localparam logic [31:0] MaskRedRst = 32'h00FF_0000;
  localparam logic [31:0] MaskGrnRst = 32'h0000_FF00;
  localparam logic [31:0] MaskBluRst = 32'h0000_00FF;
  localparam logic [31:0] MaskAlpRst = 32'hFF00_0000;

  // position of the lowest set bit, 0 for an empty mask
  function automatic logic [4:0] low_bit_pos(input logic [31:0] m);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (m[i]) p = 5'(i);
    end
    return p;
  endfunction

endpackage

`default_nettype wire

### src/bmp_unpack.sv
// Pixel unpacking: 24-bit BGR bytes or a 32-bit bit-field word to ARGB.
// Depends on bmp_pkg for the channel mask types.
`default_nettype none

module bmp_unpack (
  input  wire logic              mode_32bit_i,
  input  wire logic [23:0]       partial_word_i,
  input  wire logic [7:0]        pixel_byte_i,
  input  wire bmp_pkg::chan_set_t chan_i,
  output logic [31:0]            pixel_argb_o
);

  logic [31:0] word;

  function automatic logic [7:0] extract(input logic [31:0] w, input bmp_pkg::chan_cfg_t c);
    logic [31:0] sh;
    sh = (w & c.mask) >> c.shift;
    return (c.mask == 32'd0) ? 8'd0 : sh[7:0];
  endfunction

  assign word = {pixel_byte_i, partial_word_i};

  always_comb begin
    if (mode_32bit_i) begin
      pixel_argb_o = {extract(word, chan_i.alpha), extract(word, chan_i.red),
                      extract(word, chan_i.green), extract(word, chan_i.blue)};
    end else begin
      pixel_argb_o = {8'd0, pixel_byte_i, partial_word_i[15:0]};
    end
  end

endmodule

`default_nettype wire

### src/bmp_pixel_row_decoder.sv
// Top level of the BMP pixel row decoder: byte assembly, padding skip, row flip.
// Depends on bmp_pkg and bmp_unpack.
`default_nettype none

// Takes one pixel-array byte per clock on the input channel whenever the
// output register is empty or being drained in the same cycle, and delivers
// one ARGB pixel with its top-down destination index on every third (24-bit)
// or fourth (32-bit) data byte; row pad bytes are consumed without a result.
// Each byte's work runs in a single pass from the decoder state to the output
// register. The user must write configuration through the write port only
// while no image is in progress; the block does not enforce this. Masks,
// width and height take effect on the next byte.
module bmp_pixel_row_decoder #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  pixel_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      pixel_argb_o,
  output logic [23:0]      dest_index_o,
  output logic             end_of_image_o
);

  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned IdxW = bmp_pkg::IdxW;

  logic               mode_q, bottom_up_q;
  logic [WW-1:0]      w_q;
  logic [HW-1:0]      h_q;
  bmp_pkg::chan_set_t chan_q;

  logic [1:0]         phase_q, phase_d;
  logic [23:0]        partial_q, partial_d;
  logic [WW-1:0]      col_q, col_d, col_next;
  logic [HW-1:0]      row_q, row_d, row_next;
  logic [1:0]         pad_q, pad_d;
  logic [IdxW-1:0]    row_base_q, row_base_d;

  logic               out_valid_q;
  logic [31:0]        argb_q;
  logic [IdxW-1:0]    dest_q;
  logic               end_q;

  logic               accept;
  logic               res_valid, res_end;
  logic [IdxW-1:0]    res_dest;
  logic [31:0]        res_argb;
  logic [1:0]         last;
  logic [31:0]        wr_dim;
  logic [WW-1:0]      wr_w;
  logic [HW-1:0]      wr_h;
  logic [HW+WW-1:0]   prod;
  logic [HW+WW+23:0]  prod_ext;
  logic [IdxW-1:0]    start_base;

  // ---------------------------------------------------------------- config
  assign wr_dim = {19'd0, cfg_wdata_i[12:0]};
  assign wr_w = (wr_dim == 32'd0) ? WW'(1) :
                (wr_dim > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(wr_dim);
  assign wr_h = (wr_dim == 32'd0) ? HW'(1) :
                (wr_dim > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(wr_dim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q            <= 1'b0;
      w_q               <= WW'(1);
      h_q               <= HW'(1);
      bottom_up_q       <= 1'b1;
      chan_q.red.mask   <= bmp_pkg::MaskRedRst;
      chan_q.red.shift  <= 5'd16;
      chan_q.green.mask <= bmp_pkg::MaskGrnRst;
      chan_q.green.shift <= 5'd8;
      chan_q.blue.mask  <= bmp_pkg::MaskBluRst;
      chan_q.blue.shift <= 5'd0;
      chan_q.alpha.mask <= bmp_pkg::MaskAlpRst;
      chan_q.alpha.shift <= 5'd24;
    end else if (cfg_we_i) begin
      unique case (bmp_pkg::cfg_reg_e'(cfg_index_i))
        bmp_pkg::CfgMode32:   mode_q <= cfg_wdata_i[0];
        bmp_pkg::CfgWidth:    w_q <= wr_w;
        bmp_pkg::CfgHeight:   h_q <= wr_h;
        bmp_pkg::CfgBottomUp: bottom_up_q <= cfg_wdata_i[0];
        bmp_pkg::CfgMaskRed:  chan_q.red <= '{cfg_wdata_i, bmp_pkg::low_bit_pos(cfg_wdata_i)};
        bmp_pkg::CfgMaskGrn:  chan_q.green <= '{cfg_wdata_i, bmp_pkg::low_bit_pos(cfg_wdata_i)};
        bmp_pkg::CfgMaskBlu:  chan_q.blue <= '{cfg_wdata_i, bmp_pkg::low_bit_pos(cfg_wdata_i)};
        bmp_pkg::CfgMaskAlp:  chan_q.alpha <= '{cfg_wdata_i, bmp_pkg::low_bit_pos(cfg_wdata_i)};
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath
  bmp_unpack u_unpack (
    .mode_32bit_i   (mode_q),
    .partial_word_i (partial_q),
    .pixel_byte_i   (pixel_byte_i),
    .chan_i         (chan_q),
    .pixel_argb_o   (res_argb)
  );

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign last       = mode_q ? 2'd3 : 2'd2;
  assign prod       = (h_q - HW'(1)) * w_q;
  assign prod_ext   = {24'd0, prod};
  assign start_base = bottom_up_q ? prod_ext[IdxW-1:0] : '0;
  assign col_next   = col_q + WW'(1);
  assign row_next   = row_q + HW'(1);
  assign res_dest   = row_base_q + IdxW'(col_q);

  always_comb begin
    phase_d    = phase_q;
    partial_d  = partial_q;
    col_d      = col_q;
    row_d      = row_q;
    pad_d      = pad_q;
    row_base_d = row_base_q;
    res_valid  = 1'b0;
    res_end    = 1'b0;
    if (accept) begin
      if (pad_q != 2'd0) begin
        pad_d = pad_q - 2'd1;
      end else begin
        if (phase_q == 2'd0 && col_q == '0 && row_q == '0) begin
          row_base_d = start_base;
        end
        if (phase_q < last) begin
          partial_d = partial_q | (24'(pixel_byte_i) << {phase_q, 3'b000});
          phase_d   = phase_q + 2'd1;
        end else begin
          res_valid = 1'b1;
          phase_d   = 2'd0;
          partial_d = '0;
          if (col_next >= w_q) begin
            col_d = '0;
            pad_d = mode_q ? 2'd0 : 2'(w_q);
            if (row_next >= h_q) begin
              row_d   = '0;
              res_end = 1'b1;
            end else begin
              row_d      = row_next;
              row_base_d = bottom_up_q ? row_base_q - IdxW'(w_q)
                                       : row_base_q + IdxW'(w_q);
            end
          end else begin
            col_d = col_next;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 2'd0;
      partial_q   <= '0;
      col_q       <= '0;
      row_q       <= '0;
      pad_q       <= 2'd0;
      row_base_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      partial_q  <= partial_d;
      col_q      <= col_d;
      row_q      <= row_d;
      pad_q      <= pad_d;
      row_base_q <= row_base_d;
      if (res_valid) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      argb_q <= res_argb;
      dest_q <= res_dest;
      end_q  <= res_end;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_argb_o   = argb_q;
  assign dest_index_o   = dest_q;
  assign end_of_image_o = end_q;

`ifndef SYNTH
  a_pad_between_pixels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pad_q != 2'd0 |-> phase_q == 2'd0)
    else $error("pad skip pending inside a pixel");

  a_pad_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && pad_q != 2'd0 |=> out_valid_q == $past(out_valid_q && !out_ready_i))
    else $error("pad byte produced a result");

  a_eoi_counters_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && end_q |-> row_q == '0 && col_q == '0)
    else $error("counters not cleared after final pixel");
`endif

endmodule

`default_nettype wire
